@@ src/ssk_pkg.sv @@
// shared constants and types for the spaced-seed k-mer hash
package ssk_pkg;

    localparam int SYMBOL_BITS = 2;
    localparam int MAX_GROUPS  = 4;
    localparam int HW_GROUPS   = 4;

    localparam int WINDOW_BITS = 64;
    localparam int SHIFT_BITS  = 6;
    localparam int COUNT_BITS  = 3;
    localparam int INDEX_BITS  = 3;
    localparam int SYM_IN_BITS = 2;

    typedef logic [WINDOW_BITS-1:0] word_t;
    typedef logic [SHIFT_BITS-1:0]  shift_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [INDEX_BITS-1:0]  cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t CFG_GROUP0_MASK  = 3'd0;
    localparam cfg_index_t CFG_GROUP1_MASK  = 3'd1;
    localparam cfg_index_t CFG_GROUP1_SHIFT = 3'd2;
    localparam cfg_index_t CFG_GROUP2_MASK  = 3'd3;
    localparam cfg_index_t CFG_GROUP2_SHIFT = 3'd4;
    localparam cfg_index_t CFG_GROUP3_MASK  = 3'd5;
    localparam cfg_index_t CFG_GROUP3_SHIFT = 3'd6;
    localparam cfg_index_t CFG_GROUP_COUNT  = 3'd7;

endpackage

@@ src/spaced_seed_kmer_hash.sv @@
// spaced-seed k-mer hash: window shift register, care-group gather and output register
//
// One sequence symbol is taken per request and shifted into a 64-bit window
// (oldest bits fall off the top). The hash packs the care positions of the
// seed: window AND group0 mask, ORed with each further group's masked window
// shifted right by that group's shift, for as many groups as group_count
// selects (zero counts as one, values above four saturate). One hash leaves
// per symbol, computed from the window after that symbol has entered. The
// block sustains one symbol per clock while in_stall is low: the window
// register feeds a single level of mask, barrel shift and OR into the result
// register, which presents a symbol's hash on seed_hash until it is taken
// downstream with out_valid high and out_stall low. in_stall rises
// only while both the window stage and the result register hold undelivered
// work and the downstream side stalls. Configuration writes are taken on any
// cycle with cfg_write high and should only be issued while the block is idle.
module spaced_seed_kmer_hash
    import ssk_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_write,
    input  cfg_index_t             cfg_index,
    input  word_t                  cfg_data,

    // symbol requests in
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SYM_IN_BITS-1:0] symbol,

    // hash requests out
    output logic                   out_valid,
    input  logic                   out_stall,
    output word_t                  seed_hash
);

    // configuration registers; group zero has no shift
    word_t  mask_reg  [HW_GROUPS];
    shift_t shift_reg [1:HW_GROUPS-1];
    count_t count_reg;

    // window stage
    word_t  window_reg, window_next;
    logic   s1_valid_reg, s1_valid_next;

    // result stage
    word_t  hash_reg, hash_next;
    logic   out_valid_reg, out_valid_next;

    logic   in_acc;
    logic   s1_adv;
    count_t groups_used;
    logic [SYM_IN_BITS+7:0]  sym_wide;
    logic [SYMBOL_BITS-1:0]  sym_bits;

    // handshake control
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    assign s1_valid_next  = in_acc || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    // only the low symbol bits enter the window
    assign sym_wide = {8'd0, symbol};
    assign sym_bits = sym_wide[SYMBOL_BITS-1:0];
    assign window_next = {window_reg[WINDOW_BITS-SYMBOL_BITS-1:0], sym_bits};

    // clamp the group count to the supported range
    always_comb
    begin
        if (count_reg == '0)
        begin
            groups_used = count_t'(1);
        end
        else if (count_reg > count_t'(MAX_GROUPS))
        begin
            groups_used = count_t'(MAX_GROUPS);
        end
        else
        begin
            groups_used = count_reg;
        end
    end

    // gather the care groups of the current window
    always_comb
    begin
        hash_next = window_reg & mask_reg[0];
        for (int g = 1; g < HW_GROUPS; g++)
        begin
            if (count_t'(g) < groups_used)
            begin
                hash_next = hash_next | ((window_reg & mask_reg[g]) >> shift_reg[g]);
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[0] <= '1;
            for (int g = 1; g < HW_GROUPS; g++)
            begin
                mask_reg[g]  <= '0;
                shift_reg[g] <= '0;
            end
            count_reg <= count_t'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_GROUP0_MASK:  mask_reg[0]  <= cfg_data;
                CFG_GROUP1_MASK:  mask_reg[1]  <= cfg_data;
                CFG_GROUP1_SHIFT: shift_reg[1] <= cfg_data[SHIFT_BITS-1:0];
                CFG_GROUP2_MASK:  mask_reg[2]  <= cfg_data;
                CFG_GROUP2_SHIFT: shift_reg[2] <= cfg_data[SHIFT_BITS-1:0];
                CFG_GROUP3_MASK:  mask_reg[3]  <= cfg_data;
                CFG_GROUP3_SHIFT: shift_reg[3] <= cfg_data[SHIFT_BITS-1:0];
                CFG_GROUP_COUNT:  count_reg    <= cfg_data[COUNT_BITS-1:0];
                default:          count_reg    <= count_reg;
            endcase
        end
    end

    // window and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                window_reg <= window_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded when the window stage moves on
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            hash_reg <= hash_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign seed_hash = hash_reg;

    // never stall with an empty window stage
    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled while window stage empty");

    // an accepted symbol is held in the window stage next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted symbol lost from window stage");

    // a stalled window stage keeps its window
    a_window_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(window_reg))
        else $error("window changed while stalled");

    // the result register takes the gather of the advancing window
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg && (hash_reg == $past(hash_next)))
        else $error("result register missed advancing hash");

endmodule

@@ test/seed_hash_checker.sv @@
// checker for the spaced-seed hash: mirrors window and config, compares every hash
`timescale 1ns / 1ps

module seed_hash_checker
    import ssk_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  cfg_index_t             cfg_index,
    input  word_t                  cfg_data,

    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [SYM_IN_BITS-1:0] symbol,

    input  logic                   out_valid,
    input  logic                   out_stall,
    input  word_t                  seed_hash,

    output int                     mismatch_count,
    output int                     hashes_pending
);

    word_t  group_mask  [HW_GROUPS];
    shift_t group_shift [HW_GROUPS];
    count_t group_count;
    word_t  window_copy;
    word_t  expected_hashes [$];

    // gather the care groups of one window into the packed hash
    function automatic word_t gather_hash(word_t win);
        word_t packed_hash;
        int    groups;
        int    g;
        groups = (group_count == '0) ? 1 : int'(group_count);
        if (groups > MAX_GROUPS)
            groups = MAX_GROUPS;
        packed_hash = win & group_mask[0];
        for (g = 1; g < groups; g++)
            packed_hash |= (win & group_mask[g]) >> group_shift[g];
        return packed_hash;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        word_t want;
        word_t sym_bits;
        if (!rst_n)
        begin
            group_mask[0]  = '1;
            group_mask[1]  = '0;
            group_mask[2]  = '0;
            group_mask[3]  = '0;
            group_shift[0] = '0;
            group_shift[1] = '0;
            group_shift[2] = '0;
            group_shift[3] = '0;
            group_count    = count_t'(1);
            window_copy    = '0;
            expected_hashes.delete();
            mismatch_count = 0;
            hashes_pending = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GROUP0_MASK:  group_mask[0]  = cfg_data;
                    CFG_GROUP1_MASK:  group_mask[1]  = cfg_data;
                    CFG_GROUP1_SHIFT: group_shift[1] = cfg_data[SHIFT_BITS-1:0];
                    CFG_GROUP2_MASK:  group_mask[2]  = cfg_data;
                    CFG_GROUP2_SHIFT: group_shift[2] = cfg_data[SHIFT_BITS-1:0];
                    CFG_GROUP3_MASK:  group_mask[3]  = cfg_data;
                    CFG_GROUP3_SHIFT: group_shift[3] = cfg_data[SHIFT_BITS-1:0];
                    CFG_GROUP_COUNT:  group_count    = cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end

            // older requests leave first, so compare before queuing a new one
            if (out_valid && !out_stall)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $error("seed_hash: no hash expected, actual %h", seed_hash);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (seed_hash !== want)
                    begin
                        $error("seed_hash mismatch: expected %h, actual %h", want, seed_hash);
                        mismatch_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                sym_bits    = word_t'(symbol) & ((word_t'(1) << SYMBOL_BITS) - word_t'(1));
                window_copy = (window_copy << SYMBOL_BITS) | sym_bits;
                expected_hashes.push_back(gather_hash(window_copy));
            end

            hashes_pending = expected_hashes.size();
        end
    end

endmodule

@@ test/tb_spaced_seed_kmer_hash.sv @@
// testbench top for the spaced-seed k-mer hash: stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module tb_spaced_seed_kmer_hash;
    import ssk_pkg::*;

    // idling odds per cycle, in percent, for both sides
    localparam int IDLE_PCT        = 38;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 230;
    // phase in which the sender never idles
    localparam int QUIET_PHASE     = 2;
    // two register stages inside the block, plus some margin
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 200000;

    // opening symbols, taken two bits at a time from the low end:
    // defaults (8), count zero (4), four groups with extreme shifts (6),
    // saturated count with a typical seed (6)
    localparam logic [47:0] DIRECTED_SYMS = {
        2'd1, 2'd2, 2'd3, 2'd0, 2'd3, 2'd3,
        2'd2, 2'd1, 2'd3, 2'd3, 2'd0, 2'd3,
        2'd3, 2'd2, 2'd1, 2'd3,
        2'd2, 2'd0, 2'd3, 2'd3, 2'd2, 2'd1, 2'd3, 2'd0
    };

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    cfg_index_t             cfg_index = CFG_GROUP0_MASK;
    word_t                  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [SYM_IN_BITS-1:0] symbol    = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    word_t                  seed_hash;

    int                     mismatch_count;
    int                     hashes_pending;

    spaced_seed_kmer_hash uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .symbol    (symbol),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .seed_hash (seed_hash)
    );

    seed_hash_checker hash_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .symbol         (symbol),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .seed_hash      (seed_hash),
        .mismatch_count (mismatch_count),
        .hashes_pending (hashes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // every task below starts and ends just after a rising edge, so each
    // input changes by one nonblocking assignment at that edge

    // one register write; the enable drops again before the next one
    task automatic write_reg(cfg_index_t idx, word_t value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // full seed layout, register by register in index order
    task automatic load_seed(word_t m0, word_t m1, word_t s1, word_t m2, word_t s2,
                             word_t m3, word_t s3, word_t count);
        write_reg(CFG_GROUP0_MASK,  m0);
        write_reg(CFG_GROUP1_MASK,  m1);
        write_reg(CFG_GROUP1_SHIFT, s1);
        write_reg(CFG_GROUP2_MASK,  m2);
        write_reg(CFG_GROUP2_SHIFT, s2);
        write_reg(CFG_GROUP3_MASK,  m3);
        write_reg(CFG_GROUP3_SHIFT, s3);
        write_reg(CFG_GROUP_COUNT,  count);
    endtask

    // offer one symbol request, with optional random idle cycles first,
    // and hold it until the block takes it
    task automatic send_symbol(logic [SYM_IN_BITS-1:0] sym, bit may_idle);
        if (may_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_directed(int first, int count);
        int i;
        for (i = first; i < first + count; i++)
            send_symbol(DIRECTED_SYMS[2*i +: 2], 1'b1);
    endtask

    // stop offering, wait for every queued hash, then let the pipe settle
    task automatic drain_hashes();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (hashes_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // masks: empty, full, random, one contiguous run, or a single bit
    function automatic word_t pick_mask();
        int    len;
        int    pos;
        word_t m;
        case ($urandom_range(0, 5))
            0: m = '0;
            1: m = '1;
            4:
            begin
                len = $urandom_range(1, WINDOW_BITS);
                pos = $urandom_range(0, WINDOW_BITS - len);
                m   = (len == WINDOW_BITS) ? '1 : ((word_t'(1) << len) - word_t'(1)) << pos;
            end
            5: m = word_t'(1) << $urandom_range(0, WINDOW_BITS - 1);
            default: m = {$urandom, $urandom};
        endcase
        return m;
    endfunction

    // shifts lean towards the ends; upper bits carry junk half the time
    function automatic word_t pick_shift();
        word_t s;
        case ($urandom_range(0, 3))
            0: s = '0;
            1: s = word_t'(63);
            default: s = word_t'($urandom_range(0, 63));
        endcase
        if ($urandom_range(0, 1))
            s |= {$urandom, $urandom} & ~word_t'(63);
        return s;
    endfunction

    // every count code including zero and the ones above four
    function automatic word_t pick_count();
        word_t c;
        c = word_t'($urandom_range(0, 7));
        if ($urandom_range(0, 1))
            c |= {$urandom, $urandom} & ~word_t'(7);
        return c;
    endfunction

    // receiver: random stalls, one quiet stretch, and a recurring long hold-off
    // so the block fills up and stalls its input
    initial
    begin : receiver
        int rx_cycle;
        int hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (hold_left == 0 && rx_cycle % 3000 == 1200)
                hold_left = 90;
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (rx_cycle >= 2000 && rx_cycle < 2600)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_spaced_seed_kmer_hash: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int                     phase;
        int                     n;
        bit                     run_mode;
        logic [SYM_IN_BITS-1:0] sym;

        sym = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout: group zero takes the whole window
        send_directed(0, 8);
        drain_hashes();

        // count field zero with junk above it, group zero masked off:
        // only group zero counts, so every hash is zero
        load_seed('0, '1, '0, '1, word_t'(5), '1, word_t'(9), 64'hFFFF_FFFF_FFFF_FFF8);
        send_directed(8, 4);
        drain_hashes();

        // four groups, full masks in groups one and three, shifts of 63, 0 and 1
        load_seed(64'h0000_0000_0000_000F, '1, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h0000_0000_0000_00F0, 64'hFFFF_FFFF_FFFF_FFC0,
                  '1, word_t'(1), word_t'(4));
        send_directed(12, 6);
        drain_hashes();

        // count of seven saturates to four; a typical gapped seed
        load_seed(64'h0000_0000_0000_0003, 64'h0000_0000_0000_0030, word_t'(2),
                  64'h0000_0000_0000_0C00, word_t'(6),
                  64'h0000_0000_000F_0000, word_t'(10), word_t'(7));
        send_directed(18, 6);
        drain_hashes();

        // random layouts; some phases stream long runs of one symbol so the
        // window fills with a single repeated two-bit pattern
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_seed(pick_mask(), pick_mask(), pick_shift(), pick_mask(), pick_shift(),
                      pick_mask(), pick_shift(), pick_count());
            run_mode = 1'($urandom_range(0, 1));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (!(run_mode && $urandom_range(0, 99) < 85))
                    sym = SYM_IN_BITS'($urandom_range(0, 3));
                send_symbol(sym, phase != QUIET_PHASE);
            end
            drain_hashes();
        end

        @(negedge clk);
        if (mismatch_count == 0 && hashes_pending == 0)
            $display("tb_spaced_seed_kmer_hash: done, clean");
        else
            $display("tb_spaced_seed_kmer_hash: done, errors");
        $finish;
    end

endmodule

@@ spaced_seed_kmer_hash.f @@
src/ssk_pkg.sv
src/spaced_seed_kmer_hash.sv
test/seed_hash_checker.sv
test/tb_spaced_seed_kmer_hash.sv
